/* design/brl_pkg.sv */
// brl_pkg: shared types and constants for the line rasterizer
// no dependencies; imported by the front, queue, back and top modules

package brl_pkg;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic x_is_major;
    logic x_goes_down;
    logic y_goes_down;
  } flags_t;

  localparam int FLAG_BITS   = $bits(flags_t);
  localparam int QUEUE_DEPTH = 2;

endpackage

/* design/brl_if.sv */
// brl_in_if and brl_out_if: valid/ready channels of the line rasterizer
// no dependencies; used by brl_front, brl_back and the top level

interface brl_in_if #(parameter int COORD_BITS = 11) ();
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, command, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, command, x_start, y_start, x_end, y_end, output ready);
endinterface

interface brl_out_if #(parameter int COORD_BITS = 11) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

/* design/brl_front.sv */
// brl_front: takes input words, classifies load or step, works out deltas and octant
// depends on brl_pkg and brl_in_if

module brl_front #(
  parameter int COORD_BITS = 11
) (
  brl_in_if.sink                 in_if,
  input  logic                   q_full,
  output logic                   q_push,
  output brl_pkg::flags_t        q_flags,
  output logic [COORD_BITS-1:0]  q_x,
  output logic [COORD_BITS-1:0]  q_y,
  output logic [COORD_BITS-1:0]  q_major,
  output logic [COORD_BITS-1:0]  q_minor
);
  import brl_pkg::*;

  logic                  x_down;
  logic                  y_down;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  x_major;

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  always_comb begin
    x_down  = in_if.x_end < in_if.x_start;
    y_down  = in_if.y_end < in_if.y_start;
    adx     = x_down ? in_if.x_start - in_if.x_end : in_if.x_end - in_if.x_start;
    ady     = y_down ? in_if.y_start - in_if.y_end : in_if.y_end - in_if.y_start;
    x_major = ady <= adx;

    q_flags.cmd         = cmd_t'(in_if.command);
    q_flags.x_is_major  = x_major;
    q_flags.x_goes_down = x_down;
    q_flags.y_goes_down = y_down;
    q_x                 = in_if.x_start;
    q_y                 = in_if.y_start;
    q_major             = x_major ? adx : ady;
    q_minor             = x_major ? ady : adx;
  end

endmodule

/* design/brl_queue.sv */
// brl_queue: short first-in first-out buffer of classified words
// depends on brl_pkg for the depth

module brl_queue #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);
  import brl_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    slot_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_pop;

  assign full      = count_r == CNT_BITS'(QUEUE_DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_BITS'(push) - CNT_BITS'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/brl_back.sv */
// brl_back: line stepper state and registered pixel output
// depends on brl_pkg and brl_out_if

module brl_back #(
  parameter int COORD_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  e_valid,
  input  brl_pkg::flags_t       e_flags,
  input  logic [COORD_BITS-1:0] e_x,
  input  logic [COORD_BITS-1:0] e_y,
  input  logic [COORD_BITS-1:0] e_major,
  input  logic [COORD_BITS-1:0] e_minor,
  output logic                  e_pop,
  brl_out_if.source             out_if
);
  import brl_pkg::*;

  localparam int DT_BITS = COORD_BITS + 3;
  localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  logic                      active_r, active_nxt;
  logic [COORD_BITS-1:0]     cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]     cur_y_r, cur_y_nxt;
  logic signed [DT_BITS-1:0] dt_r, dt_nxt;
  logic signed [DT_BITS-1:0] inc_pos_r, inc_pos_nxt;
  logic signed [DT_BITS-1:0] inc_neg_r, inc_neg_nxt;
  logic [COORD_BITS-1:0]     steps_r, steps_nxt;
  logic                      x_major_r, x_major_nxt;
  logic                      x_down_r, x_down_nxt;
  logic                      y_down_r, y_down_nxt;

  logic                      out_valid_r;
  logic [COORD_BITS-1:0]     pix_x_r, pix_y_r;
  logic                      last_r;

  logic                      emit;
  logic [COORD_BITS-1:0]     mx, my;
  logic signed [DT_BITS-1:0] minor2, major1, major2;

  assign e_pop = e_valid && (!out_valid_r || out_if.ready);
  assign emit  = e_pop && (e_flags.cmd == CMD_STEP) && active_r;

  assign out_if.valid      = out_valid_r;
  assign out_if.pixel_x    = pix_x_r;
  assign out_if.pixel_y    = pix_y_r;
  assign out_if.last_pixel = last_r;

  always_comb begin
    minor2      = {2'b00, e_minor, 1'b0};
    major1      = {3'b000, e_major};
    major2      = {2'b00, e_major, 1'b0};
    active_nxt  = active_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    dt_nxt      = dt_r;
    inc_pos_nxt = inc_pos_r;
    inc_neg_nxt = inc_neg_r;
    steps_nxt   = steps_r;
    x_major_nxt = x_major_r;
    x_down_nxt  = x_down_r;
    y_down_nxt  = y_down_r;
    mx          = cur_x_r;
    my          = cur_y_r;

    // minor decision first, pixel out, then major advance
    if (!dt_r[DT_BITS-1]) begin
      if (x_major_r) begin
        my = y_down_r ? cur_y_r - ONE : cur_y_r + ONE;
      end else begin
        mx = x_down_r ? cur_x_r - ONE : cur_x_r + ONE;
      end
    end

    if (e_pop && e_flags.cmd == CMD_LOAD) begin
      active_nxt  = e_major != '0;
      cur_x_nxt   = e_x;
      cur_y_nxt   = e_y;
      dt_nxt      = minor2 - major1;
      inc_pos_nxt = minor2 - major2;
      inc_neg_nxt = minor2;
      steps_nxt   = e_major;
      x_major_nxt = e_flags.x_is_major;
      x_down_nxt  = e_flags.x_goes_down;
      y_down_nxt  = e_flags.y_goes_down;
    end else if (emit) begin
      dt_nxt     = dt_r + (dt_r[DT_BITS-1] ? inc_neg_r : inc_pos_r);
      cur_x_nxt  = mx;
      cur_y_nxt  = my;
      if (x_major_r) begin
        cur_x_nxt = x_down_r ? mx - ONE : mx + ONE;
      end else begin
        cur_y_nxt = y_down_r ? my - ONE : my + ONE;
      end
      steps_nxt  = steps_r - ONE;
      active_nxt = steps_r != ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      dt_r        <= '0;
      inc_pos_r   <= '0;
      inc_neg_r   <= '0;
      steps_r     <= '0;
      x_major_r   <= 1'b0;
      x_down_r    <= 1'b0;
      y_down_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      dt_r      <= dt_nxt;
      inc_pos_r <= inc_pos_nxt;
      inc_neg_r <= inc_neg_nxt;
      steps_r   <= steps_nxt;
      x_major_r <= x_major_nxt;
      x_down_r  <= x_down_nxt;
      y_down_r  <= y_down_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix_x_r <= mx;
      pix_y_r <= my;
      last_r  <= steps_r == ONE;
    end
  end

endmodule

/* design/bresenham_line_rasterizer.sv */
// bresenham_line_rasterizer: top level, front classifier, word queue and line stepper
// depends on brl_pkg, brl_in_if, brl_out_if, brl_front, brl_queue, brl_back
//
//   port     dir   word
//   in_if    sink  command, x_start, y_start, x_end, y_end
//   out_if   src   pixel_x, pixel_y, last_pixel
//
// one input word per cycle unless the queue is full, one pixel per cycle while a line runs and out_if.ready is high
// a step word taken on in_if is registered in a queue slot, then its pixel in the output register
// a two-word queue sits between front and stepper; in_if.ready drops only when it is full
// the stepper moves on while out_if.ready is high or the output register is empty
// synchronous reset clears the queue, stepper state and output valid

module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  brl_in_if.sink     in_if,
  brl_out_if.source  out_if
);
  import brl_pkg::*;

  localparam int Q_WIDTH = FLAG_BITS + 4 * COORD_BITS;

  logic                  q_full;
  logic                  q_push;
  flags_t                f_flags;
  logic [COORD_BITS-1:0] f_x, f_y, f_major, f_minor;
  logic [Q_WIDTH-1:0]    q_pop_data;
  logic                  q_pop_valid;
  logic                  q_pop;
  flags_t                b_flags;
  logic [COORD_BITS-1:0] b_x, b_y, b_major, b_minor;

  brl_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_if   (in_if),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_flags (f_flags),
    .q_x     (f_x),
    .q_y     (f_y),
    .q_major (f_major),
    .q_minor (f_minor)
  );

  brl_queue #(.WIDTH(Q_WIDTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_flags, f_x, f_y, f_major, f_minor}),
    .full      (q_full),
    .pop_valid (q_pop_valid),
    .pop       (q_pop),
    .pop_data  (q_pop_data)
  );

  assign {b_flags, b_x, b_y, b_major, b_minor} = q_pop_data;

  brl_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .e_valid (q_pop_valid),
    .e_flags (b_flags),
    .e_x     (b_x),
    .e_y     (b_y),
    .e_major (b_major),
    .e_minor (b_minor),
    .e_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule
